// File: rtl/kpv_pkg.sv
// ----------------------------------------------------------------------------
// kpv_pkg
// Shared types, constants and helpers for the position/velocity Kalman filter.
// ----------------------------------------------------------------------------
package kpv_pkg;

   // default fraction bits of the state, gain and noise words
   localparam int FRAC_BITS_DEF = 16;
   // fraction bits of the time step, fixed
   localparam int DT_BITS = 16;
   // signed multiplier operand width
   localparam int MUL_W = 34;
   // width of the prediction accumulators
   localparam int ACC_W = 36;
   // width fed into the saturation helper
   localparam int SAT_W = 72;
   // number of multiplies in the predict and correct phases
   localparam int PRED_OPS = 7;
   localparam int CORR_OPS = 6;

   // multiply selection; the accumulate that follows uses the same tag
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_DT_DT,
      MUL_DT_X1,
      MUL_DD_A,
      MUL_DT_A,
      MUL_DT_PSUM,
      MUL_DD_P11,
      MUL_DT_P11,
      MUL_K0_E,
      MUL_K1_E,
      MUL_K0_P00,
      MUL_K0_P01,
      MUL_K1_P00,
      MUL_K1_P01
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_PRED_DRAIN,
      ST_SATURATE,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_GAIN,
      ST_CORRECT,
      ST_CORR_DRAIN,
      ST_FINISH
   } ctl_state_type;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      REG_PROCESS_NOISE = 2'd0,
      REG_MEASURE_NOISE = 2'd1,
      REG_INIT_POS      = 2'd2,
      REG_INIT_SPEED    = 2'd3
   } reg_index_type;

   // controller to datapath
   typedef struct packed {
      logic        load_in;
      logic        sat_pred;
      logic        div_load;
      logic        div_step;
      logic        gain_load;
      logic        out_load;
      mul_sel_type mul_op;
   } kpv_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } kpv_status_type;

   // clamp a wide signed value to the 32-bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(32'sh7fffffff);
      lo = -SAT_W'(33'sh080000000);
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

// File: rtl/kpv_controller.sv
// ----------------------------------------------------------------------------
// kpv_controller
// Sequencer for one filter step: predict multiplies, saturation, gain
// division, correct multiplies and result hand-off.
// ----------------------------------------------------------------------------
module kpv_controller
   import kpv_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  kpv_status_type status,
   output kpv_cmd_type    cmd
);

   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   ctl_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // hold state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // advance through the step
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      cmd.mul_op = MUL_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               cnt_in      = '0;
               state_in    = ST_PREDICT;
            end
         end
         ST_PREDICT: begin
            cmd.mul_op = mul_sel_type'(4'(int'(MUL_DT_DT) + int'(cnt_ff)));
            if (cnt_ff == CNT_W'(PRED_OPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_PRED_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PRED_DRAIN: begin
            state_in = ST_SATURATE;
         end
         ST_SATURATE: begin
            cmd.sat_pred = 1'b1;
            state_in     = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_GAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_GAIN: begin
            cmd.gain_load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_CORRECT;
         end
         ST_CORRECT: begin
            cmd.mul_op = mul_sel_type'(4'(int'(MUL_K0_E) + int'(cnt_ff)));
            if (cnt_ff == CNT_W'(CORR_OPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_CORR_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CORR_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result loads only into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a pending word");

   // an accepted word starts the predict phase
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_PREDICT && cnt_ff == '0))
      else $error("accepted word did not start predict");

   // divide iterations stay within the quotient width
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (cnt_ff < CNT_W'(NUM_W)))
      else $error("divide counter overran");

   // the gain is taken right after the last divide iteration
   a_gain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN) |-> ($past(state_ff) == ST_DIVIDE))
      else $error("gain loaded without a finished divide");

endmodule

// File: rtl/kpv_datapath.sv
// ----------------------------------------------------------------------------
// kpv_datapath
// Configuration registers, filter state, shared multiplier with accumulate
// stage, paired restoring dividers for the gains, and the result register.
// ----------------------------------------------------------------------------
module kpv_datapath
   import kpv_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  kpv_cmd_type        cmd,
   output kpv_status_type     status,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic [15:0]        in_time_step,
   input  logic signed [31:0] in_accel,
   input  logic signed [31:0] in_measured_pos,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [31:0] out_est_pos,
   output logic signed [31:0] out_est_speed
);

   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int DEN_W = 34;
   localparam int REM_W = DEN_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   // configuration
   logic [30:0]        q_ff, r_ff;
   logic signed [31:0] ipos_ff, ispd_ff;
   // filter state
   logic signed [31:0] x0_ff, x1_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   // step inputs and predicted values
   logic [15:0]        dt_ff, dd_ff;
   logic signed [31:0] a_ff, z_ff;
   logic signed [ACC_W-1:0] acc0_ff, acc1_ff, acc2_ff, acc3_ff, acc4_ff;
   logic signed [31:0] x0p_ff, x1p_ff, p00p_ff, p01p_ff, p10p_ff, p11p_ff;
   logic signed [31:0] e_ff, k0_ff, k1_ff;
   // multiplier
   logic signed [PROD_W-1:0] prod_ff;
   mul_sel_type             tag_ff;
   logic signed [MUL_W-1:0] ma, mb;
   logic signed [PROD_W-1:0] sh16, sh17, shf;
   // dividers
   logic [REM_W-1:0] rem0_ff, rem1_ff;
   logic [NUM_W-1:0] quo0_ff, quo1_ff;
   logic [DEN_W-1:0] den_ff;
   logic             neg0_ff, neg1_ff, den_zero_ff;
   logic [REM_W-1:0] trial0, trial1;
   logic signed [DEN_W-1:0] den_s;
   logic [31:0]      mag00, mag10;
   // result
   logic               out_valid_ff;
   logic signed [31:0] out_pos_ff, out_spd_ff;

   function automatic logic signed [31:0] gain_sat(input logic [NUM_W-1:0] mag,
                                                   input logic neg, input logic zero);
      if (zero) begin
         return '0;
      end else if (neg) begin
         if (mag > NUM_W'(64'h80000000)) return 32'sh80000000;
         return -$signed(mag[31:0]);
      end
      if (mag > NUM_W'(64'h7fffffff)) return 32'sh7fffffff;
      return $signed(mag[31:0]);
   endfunction

   // select multiplier operands
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.mul_op)
         MUL_DT_DT:   begin ma = MUL_W'(dt_ff); mb = MUL_W'(dt_ff); end
         MUL_DT_X1:   begin ma = MUL_W'(dt_ff); mb = MUL_W'(x1_ff); end
         MUL_DD_A:    begin ma = MUL_W'(dd_ff); mb = MUL_W'(a_ff); end
         MUL_DT_A:    begin ma = MUL_W'(dt_ff); mb = MUL_W'(a_ff); end
         MUL_DT_PSUM: begin
            ma = MUL_W'(dt_ff);
            mb = MUL_W'(p01_ff) + MUL_W'(p10_ff);
         end
         MUL_DD_P11:  begin ma = MUL_W'(dd_ff); mb = MUL_W'(p11_ff); end
         MUL_DT_P11:  begin ma = MUL_W'(dt_ff); mb = MUL_W'(p11_ff); end
         MUL_K0_E:    begin ma = MUL_W'(k0_ff); mb = MUL_W'(e_ff); end
         MUL_K1_E:    begin ma = MUL_W'(k1_ff); mb = MUL_W'(e_ff); end
         MUL_K0_P00:  begin ma = MUL_W'(k0_ff); mb = MUL_W'(p00p_ff); end
         MUL_K0_P01:  begin ma = MUL_W'(k0_ff); mb = MUL_W'(p01p_ff); end
         MUL_K1_P00:  begin ma = MUL_W'(k1_ff); mb = MUL_W'(p00p_ff); end
         MUL_K1_P01:  begin ma = MUL_W'(k1_ff); mb = MUL_W'(p01p_ff); end
         default:     begin ma = '0; mb = '0; end
      endcase
   end

   assign sh16 = prod_ff >>> DT_BITS;
   assign sh17 = prod_ff >>> (DT_BITS + 1);
   assign shf  = prod_ff >>> FRAC_BITS;

   // divider trial subtracts and operand magnitudes
   assign trial0 = {rem0_ff[REM_W-2:0], quo0_ff[NUM_W-1]} - {1'b0, den_ff};
   assign trial1 = {rem1_ff[REM_W-2:0], quo1_ff[NUM_W-1]} - {1'b0, den_ff};
   assign den_s  = DEN_W'(p00p_ff) + $signed(DEN_W'(r_ff));
   assign mag00  = p00p_ff[31] ? 32'(-p00p_ff) : 32'(p00p_ff);
   assign mag10  = p10p_ff[31] ? 32'(-p10p_ff) : 32'(p10p_ff);

   // configuration and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff    <= 31'd65536;
         r_ff    <= 31'd65536;
         ipos_ff <= '0;
         ispd_ff <= '0;
         x0_ff   <= '0;
         x1_ff   <= '0;
         p00_ff  <= ONE;
         p01_ff  <= '0;
         p10_ff  <= '0;
         p11_ff  <= ONE;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_PROCESS_NOISE: q_ff <= csr_data[30:0];
            REG_MEASURE_NOISE: r_ff <= csr_data[30:0];
            REG_INIT_POS: begin
               ipos_ff <= csr_data;
               x0_ff   <= csr_data;
               x1_ff   <= ispd_ff;
               p00_ff  <= ONE;
               p01_ff  <= '0;
               p10_ff  <= '0;
               p11_ff  <= ONE;
            end
            REG_INIT_SPEED: begin
               ispd_ff <= csr_data;
               x0_ff   <= ipos_ff;
               x1_ff   <= csr_data;
               p00_ff  <= ONE;
               p01_ff  <= '0;
               p10_ff  <= '0;
               p11_ff  <= ONE;
            end
            default: ;
         endcase
      end else begin
         // apply correction products to the state
         case (tag_ff)
            MUL_K0_E:   x0_ff  <= sat32(SAT_W'(x0p_ff) + SAT_W'(shf));
            MUL_K1_E:   x1_ff  <= sat32(SAT_W'(x1p_ff) + SAT_W'(shf));
            MUL_K0_P00: p00_ff <= sat32(SAT_W'(p00p_ff) - SAT_W'(shf));
            MUL_K0_P01: p01_ff <= sat32(SAT_W'(p01p_ff) - SAT_W'(shf));
            MUL_K1_P00: p10_ff <= sat32(SAT_W'(p10p_ff) - SAT_W'(shf));
            MUL_K1_P01: p11_ff <= sat32(SAT_W'(p11p_ff) - SAT_W'(shf));
            default: ;
         endcase
      end
   end

   // multiplier tag register
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= MUL_NONE;
      end else begin
         tag_ff <= cmd.mul_op;
      end
   end

   // step datapath
   always_ff @(posedge clock) begin
      prod_ff <= ma * mb;
      if (cmd.load_in) begin
         dt_ff <= in_time_step;
         a_ff  <= in_accel;
         z_ff  <= in_measured_pos;
      end
      // accumulate predict products
      case (tag_ff)
         MUL_DT_DT:   dd_ff   <= prod_ff[31:16];
         MUL_DT_X1:   acc0_ff <= ACC_W'(x0_ff) + ACC_W'(sh16);
         MUL_DD_A:    acc0_ff <= acc0_ff + ACC_W'(sh17);
         MUL_DT_A:    acc1_ff <= ACC_W'(x1_ff) + ACC_W'(sh16);
         MUL_DT_PSUM: acc2_ff <= ACC_W'(p00_ff) + $signed(ACC_W'(q_ff)) + ACC_W'(sh16);
         MUL_DD_P11:  acc2_ff <= acc2_ff + ACC_W'(sh16);
         MUL_DT_P11: begin
            acc3_ff <= ACC_W'(p01_ff) + ACC_W'(sh16);
            acc4_ff <= ACC_W'(p10_ff) + ACC_W'(sh16);
         end
         default: ;
      endcase
      // saturate predicted values
      if (cmd.sat_pred) begin
         x0p_ff  <= sat32(SAT_W'(acc0_ff));
         x1p_ff  <= sat32(SAT_W'(acc1_ff));
         p00p_ff <= sat32(SAT_W'(acc2_ff));
         p01p_ff <= sat32(SAT_W'(acc3_ff));
         p10p_ff <= sat32(SAT_W'(acc4_ff));
         p11p_ff <= sat32(SAT_W'(p11_ff) + $signed(SAT_W'(q_ff)));
      end
      // load dividers and innovation
      if (cmd.div_load) begin
         rem0_ff     <= '0;
         rem1_ff     <= '0;
         quo0_ff     <= {mag00, FRAC_BITS'(0)};
         quo1_ff     <= {mag10, FRAC_BITS'(0)};
         den_ff      <= den_s[DEN_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
         neg0_ff     <= p00p_ff[31] ^ den_s[DEN_W-1];
         neg1_ff     <= p10p_ff[31] ^ den_s[DEN_W-1];
         den_zero_ff <= (den_s == '0);
         e_ff        <= sat32(SAT_W'(z_ff) - SAT_W'(x0p_ff));
      end
      // one quotient bit per cycle
      if (cmd.div_step) begin
         if (!trial0[REM_W-1]) rem0_ff <= trial0;
         else rem0_ff <= {rem0_ff[REM_W-2:0], quo0_ff[NUM_W-1]};
         quo0_ff <= {quo0_ff[NUM_W-2:0], ~trial0[REM_W-1]};
         if (!trial1[REM_W-1]) rem1_ff <= trial1;
         else rem1_ff <= {rem1_ff[REM_W-2:0], quo1_ff[NUM_W-1]};
         quo1_ff <= {quo1_ff[NUM_W-2:0], ~trial1[REM_W-1]};
      end
      if (cmd.gain_load) begin
         k0_ff <= gain_sat(quo0_ff, neg0_ff, den_zero_ff);
         k1_ff <= gain_sat(quo1_ff, neg1_ff, den_zero_ff);
      end
      if (cmd.out_load) begin
         out_pos_ff <= x0_ff;
         out_spd_ff <= x1_ff;
      end
   end

   // result word valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !out_valid_ff || out_ready;
   assign out_valid       = out_valid_ff;
   assign out_est_pos     = out_pos_ff;
   assign out_est_speed   = out_spd_ff;

endmodule

// File: rtl/kalman_pos_vel_filter.sv
// ----------------------------------------------------------------------------
// kalman_pos_vel_filter
// Two-state position/velocity Kalman filter, signed fixed point, streaming.
// ----------------------------------------------------------------------------
// One step per request word. A word takes thirteen multiplies through one
// shared 34x34 multiplier with a registered accumulate stage, plus the two
// gains from a pair of bit-serial restoring dividers that run 32 + FRAC_BITS
// iterations. A new word is accepted once the previous step has handed its
// result to the output register; that register holds the result until
// taken. Configuration writes are taken in any cycle and must only come
// while the block is idle; a write to init_pos or init_speed reloads the
// state and resets the covariance to identity.
// ----------------------------------------------------------------------------
module kalman_pos_vel_filter
   import kpv_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // time_step[15:0], accel[47:16], measured_pos[79:48]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // est_pos[31:0], est_speed[63:32]
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   kpv_cmd_type    cmd;
   kpv_status_type status;
   logic signed [31:0] est_pos, est_speed;

   kpv_controller #(.FRAC_BITS(FRAC_BITS)) u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kpv_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .in_time_step    (req_tdata[15:0]),
      .in_accel        ($signed(req_tdata[47:16])),
      .in_measured_pos ($signed(req_tdata[79:48])),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_est_pos     (est_pos),
      .out_est_speed   (est_speed)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {est_speed, est_pos};

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the position/velocity Kalman filter: a fixed-point
// predictor follows each accepted request word, a scoreboard compares every
// response word field by field, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
import kpv_pkg::*;

class kalman_scoreboard;
   logic [30:0]        q_noise;
   logic [30:0]        r_noise;
   logic signed [31:0] pos0;
   logic signed [31:0] spd0;
   longint             xv[2];
   longint             pm[4];
   logic [63:0]        est_queue[$];
   int                 errors;

   function new();
      q_noise = 31'd65536;
      r_noise = 31'd65536;
      pos0 = '0;
      spd0 = '0;
      errors = 0;
      reload();
   endfunction

   function void reload();
      xv[0] = pos0;
      xv[1] = spd0;
      pm[0] = 64'sd65536;
      pm[1] = 0;
      pm[2] = 0;
      pm[3] = 64'sd65536;
   endfunction

   // floor shift; >>> on longint is arithmetic
   function longint fsh(longint v, int s);
      return v >>> s;
   endfunction

   function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function void write_reg(reg_index_type idx, logic [31:0] val);
      case (idx)
         REG_PROCESS_NOISE: q_noise = val[30:0];
         REG_MEASURE_NOISE: r_noise = val[30:0];
         REG_INIT_POS: begin
            pos0 = val;
            reload();
         end
         REG_INIT_SPEED: begin
            spd0 = val;
            reload();
         end
         default: ;
      endcase
   endfunction

   // run one filter step and queue the estimate
   function void note_step(logic [79:0] w);
      longint dt, a, z, q, r, dd, x0p, x1p, p00p, p01p, p10p, p11p, s, k0, k1, e;
      logic [31:0] ep, es;
      dt = longint'(w[15:0]);
      a = longint'($signed(w[47:16]));
      z = longint'($signed(w[79:48]));
      q = longint'(q_noise);
      r = longint'(r_noise);
      dd = (dt * dt) >> 16;
      x0p = clamp(xv[0] + fsh(dt * xv[1], 16) + fsh(dd * a, 17));
      x1p = clamp(xv[1] + fsh(dt * a, 16));
      p00p = clamp(pm[0] + fsh(dt * (pm[1] + pm[2]), 16) + fsh(dd * pm[3], 16) + q);
      p01p = clamp(pm[1] + fsh(dt * pm[3], 16));
      p10p = clamp(pm[2] + fsh(dt * pm[3], 16));
      p11p = clamp(pm[3] + q);
      s = p00p + r;
      if (s != 0) begin
         k0 = clamp((p00p * 65536) / s);
         k1 = clamp((p10p * 65536) / s);
      end else begin
         k0 = 0;
         k1 = 0;
      end
      e = clamp(z - x0p);
      xv[0] = clamp(x0p + fsh(k0 * e, 16));
      xv[1] = clamp(x1p + fsh(k1 * e, 16));
      pm[0] = clamp(p00p - fsh(k0 * p00p, 16));
      pm[1] = clamp(p01p - fsh(k0 * p01p, 16));
      pm[2] = clamp(p10p - fsh(k1 * p00p, 16));
      pm[3] = clamp(p11p - fsh(k1 * p01p, 16));
      ep = xv[0][31:0];
      es = xv[1][31:0];
      est_queue.push_back({es, ep});
   endfunction

   function void check_estimate(logic [63:0] got);
      logic [63:0] want;
      if (est_queue.size() == 0) begin
         $error("unexpected response word %h", got);
         errors++;
         return;
      end
      want = est_queue.pop_front();
      if (got[31:0] !== want[31:0]) begin
         $error("est_pos expected %h actual %h", want[31:0], got[31:0]);
         errors++;
      end
      if (got[63:32] !== want[63:32]) begin
         $error("est_speed expected %h actual %h", want[63:32], got[63:32]);
         errors++;
      end
   endfunction
endclass

module tb;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   kalman_scoreboard board;
   bit               stall_long;
   int               step_count;

   kalman_pos_vel_filter u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // short gaps mostly, a long one now and then
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(120, 10);
   endfunction

   // drive one register write, then idle with csr_valid low
   task automatic write_csr(reg_index_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.write_reg(idx, val);
      @(posedge clock);
   endtask

   // offer one step word; the block is busy right after acceptance
   task automatic send_step(logic [15:0] dt, logic [31:0] a, logic [31:0] z, bit idle_ok);
      int g;
      g = idle_ok ? gap_len() : 0;
      repeat (g) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {z, a, dt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_step({z, a, dt});
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // wait out the pipeline before touching registers
   task automatic drain();
      while (board.est_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_val();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(1 << 20) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   // response side: random stalls, one long hold-off while steps keep coming
   initial begin
      int g;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (stall_long) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            stall_long = 1'b0;
         end
         g = (step_count > 300 && step_count < 500) ? 0 : gap_len();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid) board.check_estimate(rsp_tdata);
      end
   end

   initial begin
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = REG_PROCESS_NOISE;
      csr_data = '0;
      stall_long = 1'b0;
      step_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes at reset settings
      send_step(16'h0000, 32'h0, 32'h0, 0);
      send_step(16'hffff, 32'h7fffffff, 32'h7fffffff, 0);
      send_step(16'hffff, 32'h80000000, 32'h80000000, 0);
      send_step(16'h8000, 32'h00010000, 32'h7fffffff, 0);
      send_step(16'h0001, 32'hffffffff, 32'h80000000, 0);
      drain();
      // zero process noise, huge measure noise, init at extremes
      write_csr(REG_PROCESS_NOISE, 32'h0);
      write_csr(REG_MEASURE_NOISE, 32'h7fffffff);
      write_csr(REG_INIT_POS, 32'h7fffffff);
      write_csr(REG_INIT_SPEED, 32'h80000000);
      send_step(16'hffff, 32'h7fffffff, 32'h80000000, 0);
      send_step(16'hffff, 32'h80000000, 32'h7fffffff, 0);
      drain();
      // large process noise, small measure noise: large gains and saturation
      write_csr(REG_PROCESS_NOISE, 32'hffffffff);
      write_csr(REG_MEASURE_NOISE, 32'h1);
      write_csr(REG_INIT_POS, 32'h80000000);
      for (int i = 0; i < 6; i++) send_step(16'hffff, 32'h7fffffff, 32'h7fffffff, 0);
      drain();
      // negative covariance route toward zero innovation variance
      write_csr(REG_PROCESS_NOISE, 32'h0);
      write_csr(REG_MEASURE_NOISE, 32'h0000ffff);
      write_csr(REG_INIT_SPEED, 32'h00010000);
      for (int i = 0; i < 6; i++) send_step(16'($urandom), rand_val(), rand_val(), 0);
      drain();

      // random phases with fresh settings
      for (int ph = 0; ph < 11; ph++) begin
         write_csr(REG_PROCESS_NOISE, ph % 3 == 0 ? $urandom : $urandom_range(1 << 18));
         write_csr(REG_MEASURE_NOISE, ph % 4 == 0 ? $urandom : $urandom_range(1 << 18, 1));
         write_csr(REG_INIT_POS, rand_val());
         write_csr(REG_INIT_SPEED, rand_val());
         for (int i = 0; i < 100; i++) begin
            if (ph == 3 && i == 10) stall_long = 1'b1;
            step_count++;
            // mostly smooth tracks, sometimes extremes
            if ($urandom_range(9) < 7)
               send_step(16'($urandom_range(6554)), $urandom_range(1 << 20) - (1 << 19),
                         $urandom_range(1 << 24) - (1 << 23), ph != 3);
            else
               send_step(16'($urandom), rand_val(), rand_val(), ph != 3);
         end
         drain();
      end
      if (board.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
